[rtl/b64d_pkg.sv]
// Shared types, constants and the character classifier for the base64 stream decoder.
package b64d_pkg;

    // Error status reported with the end of a stream
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_NO_VALID   = 2'd1;
    localparam logic [1:0] ERR_INCOMPLETE = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_D0    = 8'h30;
    localparam logic [7:0] CHAR_D9    = 8'h39;

    // Bytes a full group holds
    localparam logic [1:0] GROUP_BYTES = 2'd3;
    localparam logic [1:0] PAD_MAX     = 2'd3;

    // Classified character
    typedef struct packed {
        logic       valid;   // alphabet character or pad
        logic       is_pad;
        logic [5:0] value;
    } sextet_t;

    // One group request from the front to the back
    typedef struct packed {
        logic [23:0] word;    // four sextets, first in the top bits
        logic [1:0]  nbytes;  // bytes to emit, 0..3
        logic        last;    // request closes the stream
        logic [1:0]  err;     // status for the end of stream
    } grp_req_t;

    // Map a character code to its sextet
    function automatic sextet_t decode_char(input logic [7:0] c);
        sextet_t r;
        r = '0;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r.valid = 1'b1;
            r.value = 6'(c - CHAR_UP_A);
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            r.valid = 1'b1;
            r.value = 6'(c - CHAR_LO_A + 8'd26);
        end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
            r.valid = 1'b1;
            r.value = 6'(c - CHAR_D0 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            r.valid = 1'b1;
            r.value = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.valid = 1'b1;
            r.value = 6'd63;
        end else if (c == CHAR_PAD) begin
            r.valid  = 1'b1;
            r.is_pad = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/b64d_front.sv]
// Front end: classifies characters, gathers sextets into groups and issues group requests.
module b64d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] char_code
    input  logic               s_tlast,    // last_char
    input  logic               q_full,
    output logic               q_push,
    output b64d_pkg::grp_req_t q_data
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        seen_reg, seen_next;

    b64d_pkg::sextet_t dec;
    logic              accept;
    logic              group_done;
    logic [1:0]        pad_upd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign dec      = b64d_pkg::decode_char(s_tdata);

    // State update and request build
    always_comb
    begin
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        pad_next   = pad_reg;
        seen_next  = seen_reg;
        group_done = 1'b0;
        pad_upd    = pad_reg;
        q_data     = '0;

        if (dec.is_pad && pad_reg != b64d_pkg::PAD_MAX) begin
            pad_upd = pad_reg + 2'd1;
        end

        if (dec.valid) begin
            seen_next = 1'b1;
            if (pos_reg == 2'd3) begin
                group_done    = 1'b1;
                q_data.word   = {acc_reg, dec.value};
                q_data.nbytes = b64d_pkg::GROUP_BYTES - pad_upd;
                acc_next      = '0;
                pos_next      = '0;
                pad_next      = '0;
            end else begin
                acc_next = {acc_reg[11:0], dec.value};
                pos_next = pos_reg + 2'd1;
                pad_next = pad_upd;
            end
        end

        // End of stream: status, then back to the reset state
        if (s_tlast) begin
            q_data.last = 1'b1;
            if (!seen_next) begin
                q_data.err = b64d_pkg::ERR_NO_VALID;
            end else if (pos_next != 2'd0) begin
                q_data.err = b64d_pkg::ERR_INCOMPLETE;
            end else begin
                q_data.err = b64d_pkg::ERR_OK;
            end
            acc_next  = '0;
            pos_next  = '0;
            pad_next  = '0;
            seen_next = 1'b0;
        end
    end

    assign q_push = accept && (group_done || s_tlast);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg  <= '0;
            pos_reg  <= '0;
            pad_reg  <= '0;
            seen_reg <= 1'b0;
        end else if (accept) begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            pad_reg  <= pad_next;
            seen_reg <= seen_next;
        end
    end

endmodule

[rtl/b64d_queue.sv]
// Short request queue between the front and back ends.
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64d_pkg::grp_req_t push_data,
    output logic               full,
    input  logic               pop,
    output b64d_pkg::grp_req_t pop_data,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::grp_req_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/b64d_back.sv]
// Back end: splits group requests into bytes and drives the registered output stage.
module b64d_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  b64d_pkg::grp_req_t q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,    // [7:0] out_byte
    output logic [7:0]         m_tuser,    // [0] byte_valid, [2:1] error_code, rest zero
    output logic               m_tlast     // end_of_stream
);

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    logic [7:0] byte_reg, byte_next;
    logic       bval_reg, bval_next;
    logic       eos_reg, eos_next;
    logic [1:0] err_reg, err_next;

    logic advance;
    logic final_out;

    assign advance   = !vld_reg || m_tready;
    assign final_out = (q_data.nbytes == 2'd0) || (idx_reg == q_data.nbytes - 2'd1);

    // Byte selection and request sequencing
    always_comb
    begin
        idx_next  = idx_reg;
        vld_next  = vld_reg;
        byte_next = byte_reg;
        bval_next = bval_reg;
        eos_next  = eos_reg;
        err_next  = err_reg;
        q_pop     = 1'b0;

        if (advance) begin
            vld_next = 1'b0;
            if (!q_empty) begin
                if (q_data.nbytes == 2'd0 && !q_data.last) begin
                    // group with three or more pads yields no bytes: nothing to emit
                    q_pop = 1'b1;
                end else begin
                    vld_next  = 1'b1;
                    bval_next = (q_data.nbytes != 2'd0);
                    case (idx_reg)
                        2'd0:    byte_next = q_data.word[23:16];
                        2'd1:    byte_next = q_data.word[15:8];
                        2'd2:    byte_next = q_data.word[7:0];
                        default: byte_next = 8'd0;
                    endcase
                    if (q_data.nbytes == 2'd0) begin
                        byte_next = 8'd0;
                    end
                    eos_next = final_out && q_data.last;
                    err_next = (final_out && q_data.last) ? q_data.err : b64d_pkg::ERR_OK;
                    if (final_out) begin
                        q_pop    = 1'b1;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bval_reg <= bval_next;
        eos_reg  <= eos_next;
        err_reg  <= err_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {5'd0, err_reg, bval_reg};
    assign m_tlast  = eos_reg;

endmodule

[rtl/base64_stream_decoder_core.sv]
// Top level of the streaming base64 decoder.
//
// Usage:
//   Slave side (s_*): one ASCII character per request in s_tdata, s_tlast on the
//   final character of the encoded text. Non-alphabet codes are skipped.
//   Master side (m_*): one decoded byte per request in m_tdata; m_tuser[0] flags
//   a real byte, m_tuser[2:1] carries the status (ok, no valid characters,
//   incomplete final group) on the request marked m_tlast. When the last
//   character emits no byte, one request with m_tuser[0] low closes the stream.
// Timing:
//   A character is taken every cycle while the group queue has room. The first
//   byte of a group passes through a queue entry and then the output register
//   to m_tdata, and the group's bytes leave it one per cycle while m_tready
//   is high. The single-byte output stage bounds throughput at three bytes per
//   four characters, so the input sustains one character per cycle with m_tready high.
// Reset and stall:
//   rst_n clears the group state, the queue and the output valid at once.
//   When m_tready is low the output register holds; the queue absorbs up to
//   QUEUE_DEPTH groups before s_tready drops.
module base64_stream_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_code
    input  logic       s_tlast,    // last_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [7:0] m_tuser,    // [0] byte_valid, [2:1] error_code, rest zero
    output logic       m_tlast     // end_of_stream
);

    b64d_pkg::grp_req_t push_data, pop_data;
    logic               push, pop, full, empty;

    // Character classification and grouping
    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    // Group request queue
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Byte emission
    b64d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (empty),
        .q_data   (pop_data),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
